/* hdl/fsn_pkg.sv */
// ----------------------------------------------------------------------------
// fsn_pkg - shared types and constants for the Newton square-root block
// Field widths of binary64, iteration bound, sequencer states and the
// divider result bundle.
// ----------------------------------------------------------------------------
package fsn_pkg;

  localparam int DATA_W         = 64;
  localparam int EXP_W          = 11;
  localparam int FRAC_W         = 52;
  localparam int MANT_W         = FRAC_W + 1;   // with hidden bit
  localparam int QUOT_W         = MANT_W + 2;   // quotient bits incl. guard
  localparam int QCNT_W         = $clog2(QUOT_W);
  localparam int BIAS           = 1023;
  localparam int MAX_ITERATIONS = 16;
  localparam int ITER_W         = (MAX_ITERATIONS > 1) ? $clog2(MAX_ITERATIONS) : 1;

  localparam logic [DATA_W-1:0] QNAN_BITS = 64'h7FF8_0000_0000_0000;
  localparam logic [EXP_W-1:0]  EXP_ONES  = '1;
  localparam logic [EXP_W-1:0]  HALF_BIAS = 11'd512;

  // unbiased exponent, wide enough for normalized subnormals and sums
  typedef logic signed [12:0] exp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NORM,
    ST_START,
    ST_DIV,
    ST_ADD,
    ST_CHECK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
    logic              rem_nz;
  } div_res_t;

endpackage

/* hdl/fsn_div.sv */
// ----------------------------------------------------------------------------
// fsn_div - radix-2 restoring mantissa divider
// One quotient bit per cycle; QUOT_W quotient bits per divide.
// ----------------------------------------------------------------------------
module fsn_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [fsn_pkg::MANT_W-1:0] dividend,
  input  logic [fsn_pkg::MANT_W-1:0] divisor,
  output fsn_pkg::div_res_t         res
);
  import fsn_pkg::*;

  logic [MANT_W:0]   rem_r, rem_nxt;
  logic [QUOT_W-1:0] quot_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              run_r, done_r;
  logic [MANT_W:0]   diff;
  logic              qbit;

  always_comb begin
    qbit    = (rem_r >= {1'b0, divisor});
    diff    = qbit ? (rem_r - {1'b0, divisor}) : rem_r;
    rem_nxt = {diff[MANT_W-1:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == QCNT_W'(QUOT_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {1'b0, dividend};
    end else if (run_r) begin
      rem_r  <= rem_nxt;
      quot_r <= {quot_r[QUOT_W-2:0], qbit};
    end
  end

  assign res.done   = done_r;
  assign res.quot   = quot_r;
  assign res.rem_nz = |rem_r;

endmodule

/* hdl/fsn_add.sv */
// ----------------------------------------------------------------------------
// fsn_add - positive normal adder with round-to-nearest-even and halving
// Returns the binary64 pattern of (a + b) / 2.
// ----------------------------------------------------------------------------
module fsn_add (
  input  fsn_pkg::exp_t              a_exp,
  input  logic [fsn_pkg::MANT_W-1:0] a_mant,
  input  fsn_pkg::exp_t              b_exp,
  input  logic [fsn_pkg::MANT_W-1:0] b_mant,
  output logic [fsn_pkg::DATA_W-1:0] half_bits
);
  import fsn_pkg::*;

  localparam int EXT_W = MANT_W + 3;

  exp_t              big_e, res_e;
  logic [MANT_W-1:0] big_m, sml_m;
  logic [13:0]       shamt;
  logic [EXT_W-1:0]  sml_ext, shifted, mask;
  logic              lost;
  logic [EXT_W:0]    sum;
  logic [EXT_W-1:0]  norm;
  logic [MANT_W-1:0] mant;
  logic              inc;
  logic [MANT_W:0]   rnd;
  logic [EXP_W-1:0]  biased;

  always_comb begin
    if (a_exp >= b_exp) begin
      big_e = a_exp; big_m = a_mant; sml_m = b_mant;
      shamt = 14'($signed(a_exp) - $signed(b_exp));
    end else begin
      big_e = b_exp; big_m = b_mant; sml_m = a_mant;
      shamt = 14'($signed(b_exp) - $signed(a_exp));
    end
    sml_ext = {sml_m, 3'b000};
    if (shamt >= 14'(EXT_W)) begin
      shifted = '0;
      mask    = '0;
      lost    = 1'b1;
    end else begin
      shifted = sml_ext >> shamt[5:0];
      mask    = (EXT_W'(1) << shamt[5:0]) - EXT_W'(1);
      lost    = |(sml_ext & mask);
    end
    sum = {1'b0, big_m, 3'b000} + {1'b0, shifted[EXT_W-1:1], shifted[0] | lost};
    if (sum[EXT_W]) begin
      norm  = {sum[EXT_W:2], sum[1] | sum[0]};
      res_e = big_e + 13'sd1;
    end else begin
      norm  = sum[EXT_W-1:0];
      res_e = big_e;
    end
    mant = norm[EXT_W-1:3];
    inc  = norm[2] & (norm[1] | norm[0] | mant[0]);
    rnd  = {1'b0, mant} + (MANT_W+1)'(inc);
    if (rnd[MANT_W]) begin
      mant  = rnd[MANT_W:1];
      res_e = res_e + 13'sd1;
    end else begin
      mant = rnd[MANT_W-1:0];
    end
    // halving is an exact exponent decrement for normal results
    biased    = EXP_W'(res_e - 13'sd1 + 13'(BIAS));
    half_bits = {1'b0, biased, mant[FRAC_W-1:0]};
  end

endmodule

/* hdl/float_sqrt_newton.sv */
// ----------------------------------------------------------------------------
// float_sqrt_newton - binary64 square root by Newton-Raphson iteration
// Sequencer around a shared bit-serial divider and a rounding adder.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one transaction carries a binary64 operand in in_tdata.
//   out_* : one transaction returns the binary64 root in out_tdata.
//   Zero gives +0, negatives (including -inf) give the quiet NaN, NaN of
//   either sign and +inf pass through. Other
//   operands start from an exponent-halved guess and iterate
//   y = (x/y + y)/2 until y repeats one of the last two estimates or
//   MAX_ITERATIONS steps are done.
//   Each step: divider start, divide, round, add and compare.
//   Subnormal operands add one-bit-per-cycle normalization up front.
//   The divider, one quotient bit a cycle, sets the step time.
//   One operand at a time: in_tready is high only while idle. A finished
//   result sits in the output register; if the receiver stalls, the next
//   operand may still be accepted and its result waits in the sequencer.
//   Reset (rst_n low, synchronous) returns to idle and drops out_tvalid.
// ----------------------------------------------------------------------------
module float_sqrt_newton (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [fsn_pkg::DATA_W-1:0] in_tdata,   // [63:0] operand_bits
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [fsn_pkg::DATA_W-1:0] out_tdata   // [63:0] root_bits
);
  import fsn_pkg::*;

  state_t            state_r, state_nxt;
  exp_t              ex_r, q_exp_r;
  logic [MANT_W-1:0] mx_r, q_mant_r;
  logic [DATA_W-1:0] y1_r, y2_r, yn_r, result_r;
  logic [ITER_W-1:0] iter_r;
  logic [DATA_W-1:0] out_tdata_r;
  logic              out_tvalid_r;

  logic              in_acc, load_out, special, last_step;
  logic [EXP_W-1:0]  in_exp;
  logic [DATA_W-1:0] special_bits, guess_bits;
  exp_t              y_exp;
  logic [MANT_W-1:0] y_mant;
  logic              div_start;
  div_res_t          div_res;
  logic [DATA_W-1:0] half_bits;

  // divide result rounding
  logic [MANT_W-1:0] qm;
  logic              qg, qs, qinc;
  exp_t              qe;
  logic [MANT_W:0]   qrnd;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid & in_tready;
  assign load_out  = (state_r == ST_DONE) & (~out_tvalid_r | out_tready);
  assign div_start = (state_r == ST_START);
  assign in_exp    = in_tdata[DATA_W-2 -: EXP_W];

  // estimate y1 unpacked for divider and adder; estimates are always normal
  assign y_exp  = exp_t'({2'b00, y1_r[DATA_W-2 -: EXP_W]}) - 13'(BIAS);
  assign y_mant = {1'b1, y1_r[FRAC_W-1:0]};

  always_comb begin
    special      = 1'b1;
    special_bits = in_tdata;
    if (in_tdata[DATA_W-2:0] == '0) begin
      special_bits = '0;
    end else if ((in_exp == EXP_ONES) &&
                 (!in_tdata[DATA_W-1] || (in_tdata[FRAC_W-1:0] != '0))) begin
      // NaN of either sign, or +inf
      special_bits = in_tdata;
    end else if (in_tdata[DATA_W-1]) begin
      special_bits = QNAN_BITS;
    end else begin
      special      = 1'b0;
    end
    // exponent field becomes (E >> 1) + 512, mantissa kept
    guess_bits = {1'b0, {1'b0, in_exp[EXP_W-1:1]} + HALF_BIAS, in_tdata[FRAC_W-1:0]};
  end

  always_comb begin
    if (div_res.quot[QUOT_W-1]) begin
      qm = div_res.quot[QUOT_W-1:2];
      qg = div_res.quot[1];
      qs = div_res.quot[0] | div_res.rem_nz;
      qe = ex_r - y_exp;
    end else begin
      qm = div_res.quot[QUOT_W-2:1];
      qg = div_res.quot[0];
      qs = div_res.rem_nz;
      qe = ex_r - y_exp - 13'sd1;
    end
    qinc = qg & (qs | qm[0]);
    qrnd = {1'b0, qm} + (MANT_W+1)'(qinc);
  end

  assign last_step = (yn_r == y1_r) | (yn_r == y2_r) |
                     (iter_r == ITER_W'(MAX_ITERATIONS - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (special)            state_nxt = ST_DONE;
          else if (in_exp == '0)  state_nxt = ST_NORM;
          else                    state_nxt = ST_START;
        end
      end
      ST_NORM:  if (mx_r[MANT_W-1]) state_nxt = ST_START;
      ST_START: state_nxt = ST_DIV;
      ST_DIV:   if (div_res.done) state_nxt = ST_ADD;
      ST_ADD:   state_nxt = ST_CHECK;
      ST_CHECK: state_nxt = last_step ? ST_DONE : ST_START;
      ST_DONE:  if (load_out) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= (out_tvalid_r & ~out_tready) | load_out;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          result_r <= special_bits;
          y1_r     <= guess_bits;
          y2_r     <= guess_bits;
          iter_r   <= '0;
          if (in_exp == '0) begin
            mx_r <= {1'b0, in_tdata[FRAC_W-1:0]};
            ex_r <= -13'sd1022;
          end else begin
            mx_r <= {1'b1, in_tdata[FRAC_W-1:0]};
            ex_r <= exp_t'({2'b00, in_exp}) - 13'(BIAS);
          end
        end
      end
      ST_NORM: begin
        if (!mx_r[MANT_W-1]) begin
          mx_r <= {mx_r[MANT_W-2:0], 1'b0};
          ex_r <= ex_r - 13'sd1;
        end
      end
      ST_DIV: begin
        if (div_res.done) begin
          if (qrnd[MANT_W]) begin
            q_mant_r <= qrnd[MANT_W:1];
            q_exp_r  <= qe + 13'sd1;
          end else begin
            q_mant_r <= qrnd[MANT_W-1:0];
            q_exp_r  <= qe;
          end
        end
      end
      ST_ADD: yn_r <= half_bits;
      ST_CHECK: begin
        if (last_step) begin
          result_r <= yn_r;
        end else begin
          y2_r   <= y1_r;
          y1_r   <= yn_r;
          iter_r <= iter_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_out) out_tdata_r <= result_r;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  fsn_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mx_r),
    .divisor  (y_mant),
    .res      (div_res)
  );

  fsn_add u_add (
    .a_exp     (q_exp_r),
    .a_mant    (q_mant_r),
    .b_exp     (y_exp),
    .b_mant    (y_mant),
    .half_bits (half_bits)
  );

endmodule

/* hdl/fsn_checker.sv */
// ----------------------------------------------------------------------------
// fsn_checker - port-level checks for float_sqrt_newton
// Watches the stream ports; attached to the top level by bind.
// ----------------------------------------------------------------------------
module fsn_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_tvalid,
  input logic                       in_tready,
  input logic [fsn_pkg::DATA_W-1:0] in_tdata,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [fsn_pkg::DATA_W-1:0] out_tdata
);
  import fsn_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed under stall");

  // one operand in flight: busy right after a transaction
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("ready after accepting operand");

  // a result appears only after the block was busy
  a_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result without work");

  // reset empties the output
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("out_tvalid after reset");

endmodule

bind float_sqrt_newton fsn_checker u_fsn_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
